>>> design/hsis_pkg.sv
`default_nettype none

package hsis_pkg;

  // Default configuration of the set.
  localparam int unsigned NUM_BUCKETS_DEF = 128;
  localparam int unsigned WAYS_DEF        = 8;
  localparam int unsigned KEY_BITS_DEF    = 16;

  // Fixed field widths of the stream payload.
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned OUT_DATA_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Operation codes carried in tuser.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture opcode and key of an accepted transaction
    logic clr_step;  // clear one bucket fill entry
    logic mod_step;  // one step of the bucket remainder
    logic rd_en;     // read the bucket row and its fill count
    logic exec;      // compare, update and load the result register
  } hsis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // last bucket is being cleared
    logic mod_last;  // last remainder step is being processed
    logic out_free;  // result register can take a new result
  } hsis_sts_t;

endpackage

`default_nettype wire

>>> design/hsis_ctrl.sv
`default_nettype none

module hsis_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hsis_pkg::hsis_sts_t sts_i,
  output hsis_pkg::hsis_cmd_t     cmd_o
);
  import hsis_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;

  always_comb begin
    state_d = state_q;
    ready_d = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
          ready_d = 1'b1;
        end
      end
      ST_IDLE: begin
        ready_d = 1'b1;
        if (in_valid_i && ready_q) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MOD;
          ready_d    = 1'b0;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
          ready_d    = 1'b1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign in_ready_o = ready_q;

endmodule

`default_nettype wire

>>> design/hsis_dp.sv
`default_nettype none

module hsis_dp #(
  parameter int unsigned NUM_BUCKETS = hsis_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned WAYS        = hsis_pkg::WAYS_DEF,
  parameter int unsigned KEY_BITS    = hsis_pkg::KEY_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hsis_pkg::hsis_cmd_t          cmd_i,
  output hsis_pkg::hsis_sts_t               sts_o,
  input  wire logic                         opcode_i,
  input  wire logic [hsis_pkg::KEY_W-1:0]   key_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              found_o,
  output logic                              bucket_full_o,
  output logic [hsis_pkg::COUNT_W-1:0]      element_total_o
);
  import hsis_pkg::*;

  localparam int unsigned BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned FW    = $clog2(WAYS + 1);
  localparam int unsigned ROW_W = WAYS * KEY_BITS;
  // Scaled reciprocal of the bucket count: exact quotient for every key below 2^KEY_BITS.
  localparam int unsigned RSH   = KEY_BITS + BW;
  localparam int unsigned MW    = KEY_BITS + 2;
  localparam int unsigned PW    = (2 * KEY_BITS + 2 > KEY_BITS + 2 * BW) ?
                                  2 * KEY_BITS + 2 : KEY_BITS + 2 * BW;
  localparam logic [MW-1:0]  RECIP    =
    MW'(((64'd1 << RSH) + 64'(NUM_BUCKETS - 1)) / 64'(NUM_BUCKETS));
  localparam logic [BW-1:0]  NB_LOW   = BW'(NUM_BUCKETS);
  localparam logic [BW-1:0]  LAST_BKT = BW'(NUM_BUCKETS - 1);
  localparam logic [FW-1:0]  WAYS_C   = FW'(WAYS);

  // Bucket storage: one row of WAYS keys and one fill count per bucket.
  logic [ROW_W-1:0] row_mem  [NUM_BUCKETS];
  logic [FW-1:0]    fill_mem [NUM_BUCKETS];

  logic             op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [BW-1:0]    quot_q;
  logic [BW-1:0]    bucket_q;
  logic             mod_ph_q;
  logic [BW-1:0]    clr_idx_q;
  logic [ROW_W-1:0] row_rd_q;
  logic [FW-1:0]    fill_rd_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic             found_q, full_q;

  logic [31:0]         key_ext;
  logic [PW-1:0]       key_wide;
  logic [PW-1:0]       product;
  logic [BW-1:0]       bucket_d;
  logic [BW-1:0]       bucket;
  logic                hit;
  logic                is_full;
  logic [ROW_W-1:0]    row_new;
  logic                row_we;
  logic                fill_we;
  logic [BW-1:0]       fill_waddr;
  logic [FW-1:0]       fill_wdata;

  assign key_ext = 32'(key_i);
  assign bucket  = bucket_q;

  // Key mod NUM_BUCKETS in two steps: the quotient from a multiply by the reciprocal,
  // then the remainder, which only needs the low bits of the key and of quotient times
  // bucket count.
  assign key_wide = PW'(key_q);
  assign product  = key_wide * PW'(RECIP);
  assign bucket_d = key_wide[BW-1:0] - quot_q * NB_LOW;

  always_comb begin
    hit = 1'b0;
    row_new = row_rd_q;
    for (int i = 0; i < WAYS; i++) begin
      if ((FW'(i) < fill_rd_q) && (row_rd_q[i*KEY_BITS +: KEY_BITS] == key_q)) begin
        hit = 1'b1;
      end
      if (fill_rd_q == FW'(i)) begin
        row_new[i*KEY_BITS +: KEY_BITS] = key_q;
      end
    end
  end

  assign is_full = (fill_rd_q >= WAYS_C);
  assign row_we  = cmd_i.exec && (op_q == OP_INSERT) && !is_full;

  always_comb begin
    fill_we    = cmd_i.clr_step || row_we;
    fill_waddr = cmd_i.clr_step ? clr_idx_q : bucket;
    fill_wdata = cmd_i.clr_step ? '0 : fill_rd_q + FW'(1);
    count_d    = count_q;
    if (row_we && (count_q != COUNT_MAX)) begin
      count_d = count_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (row_we) begin
      row_mem[bucket] <= row_new;
    end
    if (cmd_i.rd_en) begin
      fill_rd_q <= fill_mem[bucket];
      row_rd_q  <= row_mem[bucket];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      key_q <= key_ext[KEY_BITS-1:0];
    end
    if (cmd_i.mod_step && !mod_ph_q) begin
      quot_q <= product[RSH +: BW];
    end
    if (cmd_i.exec) begin
      found_q <= (op_q == OP_SEARCH) && hit;
      full_q  <= (op_q == OP_INSERT) && is_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q    <= '0;
      mod_ph_q    <= 1'b0;
      clr_idx_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        mod_ph_q <= 1'b0;
      end else if (cmd_i.mod_step) begin
        mod_ph_q <= ~mod_ph_q;
        if (mod_ph_q) begin
          bucket_q <= bucket_d;
        end
      end
      if (cmd_i.clr_step) begin
        clr_idx_q <= clr_idx_q + BW'(1);
      end
      count_q <= count_d;
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last = (clr_idx_q == LAST_BKT);
  assign sts_o.mod_last = mod_ph_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign bucket_full_o   = full_q;
  assign element_total_o = count_q;

endmodule

`default_nettype wire

>>> design/hash_set_insert_search.sv
// Each accepted transaction forms its bucket index by reciprocal multiplication, first
// the quotient and then the remainder, then reads the row, then compares and updates;
// no new transaction is accepted until the update is done, and a stalled result holds
// the update back and so the next transaction too.
// Reset: asynchronous, active low. After reset the block sweeps the bucket fill counts,
// one bucket per cycle, and accepts no input until the sweep is done.
`default_nettype none

module hash_set_insert_search #(
  parameter int unsigned NUM_BUCKETS = hsis_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned WAYS        = hsis_pkg::WAYS_DEF,
  parameter int unsigned KEY_BITS    = hsis_pkg::KEY_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input stream.
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [hsis_pkg::KEY_W-1:0]    s_axis_tdata_i,  // [15:0] key
  input  wire logic                          s_axis_tuser_i,  // [0] opcode
  // Result stream.
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [0] found, [1] bucket_full, [14:2] element_total, [15] zero
  output logic [hsis_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import hsis_pkg::*;

  // The controller sequences each transaction through remainder, read and update
  // phases; the datapath holds the bucket memories, the key register and the
  // result register that parts the two stream sides.
  hsis_cmd_t          cmd;
  hsis_sts_t          sts;
  logic               found;
  logic               bucket_full;
  logic [COUNT_W-1:0] element_total;

  hsis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hsis_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (s_axis_tuser_i),
    .key_i           (s_axis_tdata_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .found_o         (found),
    .bucket_full_o   (bucket_full),
    .element_total_o (element_total)
  );

  // Pack the result fields from the lowest bit up and pad to whole bytes.
  assign m_axis_tdata_o = OUT_DATA_W'({element_total, bucket_full, found});

endmodule

`default_nettype wire

>>> tb/hash_set_insert_search_tb.sv
`default_nettype none

module hash_set_insert_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsis_pkg::*;

  // The block is built with its default geometry, so the shadow set uses the same.
  localparam int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF;
  localparam int unsigned WAYS        = WAYS_DEF;

  // The tail after draining is counted in item periods, the spacing at which the
  // block takes transactions.
  localparam int unsigned ITEM_PERIOD    = 5;
  localparam int unsigned TAIL_CYCLES    = 4 * ITEM_PERIOD;
  // Longest quiet stretch allowed: the clearing sweep after reset, or a full period
  // plus a long receiver stall, taken many times over.
  localparam int unsigned QUIET_LIMIT    = 4000;
  localparam int unsigned RANDOM_ITEMS   = 1300;
  localparam int unsigned PHASE_ITEMS    = 130;
  localparam int unsigned MAX_REPORTS    = 50;

  // Pacing of the two stream sides.
  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SRC_GAPS,
    PACE_SNK_STALLS,
    PACE_BOTH
  } pace_e;

  // One operation waiting to be offered on the input stream.
  typedef struct {
    logic             op;
    logic [KEY_W-1:0] key;
    pace_e            pace;
    bit               drain;  // hold off until every outstanding result has come back
  } set_op_t;

  // What the block should answer for one operation.
  typedef struct {
    logic               op;
    logic [KEY_W-1:0]   key;
    logic               found;
    logic               full;
    logic [COUNT_W-1:0] total;
  } set_reply_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [KEY_W-1:0]      s_axis_tdata  = '0;  // [15:0] key
  logic                  s_axis_tuser  = OP_INSERT;  // [0] opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // [0] found, [1] bucket_full, [14:2] total, [15] zero

  hash_set_insert_search u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Operations not yet offered, and replies owed by the block in transaction order.
  set_op_t    pending_ops[$];
  set_reply_t owed_replies[$];

  // Shadow copy of the set. A slot is only ever read below its bucket's fill count,
  // so the key store needs no clearing.
  logic [KEY_W-1:0]   shadow_keys [NUM_BUCKETS][WAYS];
  int unsigned        shadow_fill [NUM_BUCKETS];
  logic [COUNT_W-1:0] shadow_count = '0;

  int unsigned owed_count  = 0;  // registered size of owed_replies, read by the driver
  int unsigned quiet_count = 0;
  int unsigned error_count = 0;
  pace_e       sink_pace   = PACE_FREE;

  // Keys offered for insertion so far, reused to hit stored entries and duplicates.
  logic [KEY_W-1:0] inserted_keys[$];

  // Apply one operation to the shadow set and return the reply it should produce.
  function automatic set_reply_t apply_set_op(logic op, logic [KEY_W-1:0] key);
    set_reply_t  r;
    int unsigned b;
    r.op    = op;
    r.key   = key;
    r.found = 1'b0;
    r.full  = 1'b0;
    b = key % NUM_BUCKETS;
    if (op == OP_INSERT) begin
      // A full bucket drops the insert; duplicates are stored again.
      if (shadow_fill[b] >= WAYS) begin
        r.full = 1'b1;
      end else begin
        shadow_keys[b][shadow_fill[b]] = key;
        shadow_fill[b]++;
        if (shadow_count < COUNT_MAX) begin
          shadow_count++;
        end
      end
    end else begin
      for (int i = 0; i < WAYS; i++) begin
        if (i < shadow_fill[b] && shadow_keys[b][i] == key) begin
          r.found = 1'b1;
        end
      end
    end
    r.total = shadow_count;
    return r;
  endfunction

  // Percentage of cycles in which one side holds back under a given pacing.
  function automatic int unsigned hold_pct(pace_e pace, bit sender);
    case (pace)
      PACE_SRC_GAPS:   return sender ? 70 : 0;
      PACE_SNK_STALLS: return sender ? 0 : 70;
      PACE_BOTH:       return 9;
      default:         return 0;
    endcase
  endfunction

  task automatic report_mismatch(string what, set_reply_t want, int unsigned got_val,
                                 int unsigned want_val);
    if (error_count < MAX_REPORTS) begin
      $display("%0t ns: %s mismatch (op %0d key 0x%04h): got %0d, expected %0d",
               $realtime, what, want.op, want.key, got_val, want_val);
    end
    error_count++;
  endtask

  task automatic queue_op(logic op, logic [KEY_W-1:0] key, pace_e pace, bit drain);
    set_op_t item;
    item.op    = op;
    item.key   = key;
    item.pace  = pace;
    item.drain = drain;
    pending_ops.push_back(item);
    if (op == OP_INSERT) begin
      inserted_keys.push_back(key);
    end
  endtask

  // Driver: offers the head of the queue whenever the input slot is free. A transaction
  // marked for draining is held until no reply is owed; owed_count is registered by the
  // monitor and does not yet show a transaction accepted at this very edge, so that also blocks it.
  always @(posedge clk_i or negedge rst_ni) begin
    bit slot_free;
    bit accepted;
    bit drained;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= OP_INSERT;
      sink_pace     <= PACE_FREE;
    end else begin
      accepted  = s_axis_tvalid && s_axis_tready;
      slot_free = !s_axis_tvalid || s_axis_tready;
      if (slot_free) begin
        drained = !accepted && owed_count == 0;
        if (pending_ops.size() != 0 && (!pending_ops[0].drain || drained) &&
            $urandom_range(99) >= hold_pct(pending_ops[0].pace, 1'b1)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_ops[0].key;
          s_axis_tuser  <= pending_ops[0].op;
          sink_pace     <= pending_ops[0].pace;
          void'(pending_ops.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each returned result against the oldest owed reply, then records
  // the reply owed for any operation accepted at the same edge, and paces the receiver.
  always @(posedge clk_i or negedge rst_ni) begin
    set_reply_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      owed_count    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_replies.size() == 0) begin
          want = '{op: 1'b0, key: '0, found: 1'b0, full: 1'b0, total: '0};
          report_mismatch("unexpected result", want, m_axis_tdata, 0);
        end else begin
          want = owed_replies.pop_front();
          if (m_axis_tdata[0] !== want.found) begin
            report_mismatch("found", want, m_axis_tdata[0], want.found);
          end
          if (m_axis_tdata[1] !== want.full) begin
            report_mismatch("bucket_full", want, m_axis_tdata[1], want.full);
          end
          if (m_axis_tdata[2 +: COUNT_W] !== want.total) begin
            report_mismatch("element_total", want, m_axis_tdata[2 +: COUNT_W], want.total);
          end
          if (m_axis_tdata[OUT_DATA_W-1] !== 1'b0) begin
            report_mismatch("padding bit", want, m_axis_tdata[OUT_DATA_W-1], 0);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        owed_replies.push_back(apply_set_op(s_axis_tuser, s_axis_tdata));
      end
      owed_count    <= owed_replies.size();
      m_axis_tready <= $urandom_range(99) >= hold_pct(sink_pace, 1'b0);
    end
  end

  // Count cycles in which neither stream moves a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    logic [6:0]       hot_buckets [6];
    logic [KEY_W-1:0] key;
    logic             op;
    pace_e            pace;
    int unsigned      pick;
    bit               timed_out;

    // Directed part: empty bucket, both key extremes, a duplicate insert, a bucket
    // filled to its last way and then overflowed, and searches that miss in an
    // occupied bucket.
    queue_op(OP_SEARCH, 16'h0000, PACE_FREE, 1'b0);
    queue_op(OP_INSERT, 16'h0000, PACE_FREE, 1'b0);
    queue_op(OP_INSERT, 16'h0000, PACE_FREE, 1'b0);
    queue_op(OP_SEARCH, 16'h0000, PACE_FREE, 1'b0);
    queue_op(OP_INSERT, 16'hFFFF, PACE_FREE, 1'b0);
    queue_op(OP_SEARCH, 16'hFFFF, PACE_FREE, 1'b0);
    queue_op(OP_SEARCH, 16'h007F, PACE_FREE, 1'b0);
    queue_op(OP_SEARCH, 16'h8000, PACE_FREE, 1'b0);
    for (int i = 0; i <= WAYS; i++) begin
      queue_op(OP_INSERT, KEY_W'(5 + i * NUM_BUCKETS), PACE_FREE, 1'b0);
    end
    queue_op(OP_INSERT, 16'h0005, PACE_FREE, 1'b0);
    queue_op(OP_SEARCH, KEY_W'(5 + (WAYS - 1) * NUM_BUCKETS), PACE_FREE, 1'b0);
    queue_op(OP_SEARCH, KEY_W'(5 + WAYS * NUM_BUCKETS), PACE_FREE, 1'b0);

    // A few buckets take a large share of the random traffic so that they fill up.
    foreach (hot_buckets[i]) begin
      hot_buckets[i] = 7'($urandom_range(NUM_BUCKETS - 1));
    end

    // Random part in phases of different pacing; each phase starts from an empty
    // pipeline.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ((i / PHASE_ITEMS) % 4)
        0:       pace = PACE_FREE;
        1:       pace = PACE_SRC_GAPS;
        2:       pace = PACE_SNK_STALLS;
        default: pace = PACE_BOTH;
      endcase
      op   = $urandom_range(1) ? OP_SEARCH : OP_INSERT;
      pick = $urandom_range(99);
      if (pick < 40 || inserted_keys.size() == 0) begin
        key = KEY_W'($urandom);
      end else if (pick < 70) begin
        key = {9'($urandom), hot_buckets[$urandom_range(5)]};
      end else begin
        key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      end
      queue_op(op, key, pace, i % PHASE_ITEMS == 0);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait at falling edges, clear of the clocked processes, until all has drained.
    timed_out = 1'b0;
    while (!timed_out &&
           !(pending_ops.size() == 0 && !s_axis_tvalid && owed_count == 0)) begin
      @(negedge clk_i);
      if (quiet_count >= QUIET_LIMIT) begin
        timed_out = 1'b1;
      end
    end

    if (timed_out) begin
      $display("Verification failed");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk_i);
      if (error_count == 0 && owed_replies.size() == 0) begin
        $display("Verification passed");
      end else begin
        if (owed_replies.size() != 0) begin
          $display("%0d results never arrived", owed_replies.size());
        end
        $display("Verification failed");
      end
      $finish;
    end
  end

endmodule

`default_nettype wire
